// File: hw/rtl/beat_cumulative_score_defines.svh
// Assertion macros for the beat cumulative score block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef BEAT_CUMULATIVE_SCORE_DEFINES_SVH
`define BEAT_CUMULATIVE_SCORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/bcs_pkg.sv
// Package for the beat cumulative score block: default sizes, reset values
// and the elaboration-time functions that build the transition weight table.
// Depends on nothing.
package bcs_pkg;

	localparam int DEF_HISTORY_DEPTH = 128;
	localparam int DEF_BEAT_PERIOD = 43;
	localparam int DEF_WEIGHT_SHARPNESS = 5;

	localparam logic [15:0] BLEND_RESET = 16'd58982;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;

	// Integer log2 as Q16, fraction from repeated squaring of a Q30 mantissa.
	function automatic logic [31:0] log2_q16(input logic [31:0] x);
		logic [31:0] n;
		logic [31:0] frac;
		logic [63:0] m;
		n = 32'd0;
		frac = 32'd0;
		if (x == 32'd0) begin
			return 32'd0;
		end
		for (int i = 0; i < 31; i++) begin
			if ((x >> (n + 32'd1)) != 32'd0) begin
				n = n + 32'd1;
			end
		end
		m = ({32'd0, x} << 30) >> n;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 32'd1;
				m = m >> 1;
			end
		end
		return (n << 16) | frac;
	endfunction

	// exp(-e) for a Q16 argument, rounded to Q16 and saturated.
	function automatic logic [15:0] exp_neg_q16(input logic [63:0] e_q16);
		logic [63:0] eq30;
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] v;
		eq30 = e_q16 << 14;
		n = eq30 / LN2_Q30;
		r = eq30 - n * LN2_Q30;
		term = 64'd1 << 30;
		sum = 64'sd1 <<< 30;
		if (n >= 64'd40) begin
			return 16'd0;
		end
		for (int i = 1; i <= 24; i++) begin
			term = ((term * r) >> 30) / 64'(i);
			if ((i % 2) == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		v = $unsigned(sum) >> n;
		v = (v + (64'd1 << 13)) >> 14;
		if (v > 64'd65535) begin
			v = 64'd65535;
		end
		return v[15:0];
	endfunction

	// Log-Gaussian transition weight for one lag, Q0.16.
	function automatic logic [15:0] weight_of(input int k, input int period, input int sharp);
		logic [31:0] lp;
		logic [31:0] lk;
		logic [31:0] d;
		logic [63:0] l;
		logic [63:0] x;
		logic [63:0] e;
		if (k == 0) begin
			return 16'd0;
		end
		lp = log2_q16(32'(period));
		lk = log2_q16(32'(k));
		d = (lk >= lp) ? (lk - lp) : (lp - lk);
		l = (64'(d) * LN2_Q30) >> 30;
		x = 64'(sharp) * l;
		e = (x * x) >> 17;
		return exp_neg_q16(e);
	endfunction

endpackage

// File: hw/rtl/beat_cumulative_score.sv
// Beat-tracking cumulative score: one onset sample in, one score out.
// Depends on bcs_pkg and beat_cumulative_score_defines.svh.
//
//  channel  | signals                           | payload
//  ---------+-----------------------------------+---------------------------
//  input    | s_tvalid, s_tready, s_tdata[15:0] | onset_sample
//  output   | m_tvalid, m_tready, m_tdata[15:0] | cumulative_score
//  config   | cfg_valid, cfg_ready, cfg_data    | blend_factor (alpha, Q0.16)
//
// An accepted item scans each lag in the window (65 lags at the default beat
// period of 43), skipping lags with no written score yet, drains the product
// pipeline, then blends in MULA, MULB and SUM; no new sample is taken before IDLE.
// One registered 17x16 multiplier is shared by the lag scan and the blend.
// Reset sets alpha to 0.9; a fill count marks which lags hold written scores.
// A result still waiting on the output holds the next item in its last step.
`include "beat_cumulative_score_defines.svh"

module beat_cumulative_score #(
	parameter int HISTORY_DEPTH = bcs_pkg::DEF_HISTORY_DEPTH,
	parameter int BEAT_PERIOD = bcs_pkg::DEF_BEAT_PERIOD,
	parameter int WEIGHT_SHARPNESS = bcs_pkg::DEF_WEIGHT_SHARPNESS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] onset_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] cumulative_score
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // [15:0] blend_factor
);

	localparam int LO = (BEAT_PERIOD + 1) / 2;
	localparam int HI = (2 * BEAT_PERIOD < HISTORY_DEPTH) ? 2 * BEAT_PERIOD : HISTORY_DEPTH;
	localparam bit SCAN_EMPTY = (LO > HI);
	localparam int PW = $clog2(HISTORY_DEPTH);
	localparam int FW = $clog2(HISTORY_DEPTH + 1);
	localparam int KW = $clog2(HI + 1);
	localparam int AW = FW + 1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_DRAIN = 7'b0000100,
		ST_MULA  = 7'b0001000,
		ST_MULB  = 7'b0010000,
		ST_SUM   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t        state_q;
	logic [15:0]   blend_q;
	logic [15:0]   sample_q;
	logic [KW-1:0] k_q;
	logic [PW-1:0] ptr_q;
	logic [FW-1:0] fill_q;
	logic [31:0]   best_q;
	logic [32:0]   acc_q;
	logic [15:0]   score_q;
	logic          m_tvalid_q;
	logic [15:0]   m_tdata_q;

	logic          v_s1;
	logic [15:0]   rd_s1;
	logic [15:0]   w_s1;
	logic          v_s2;
	logic [32:0]   prod_s2;

	logic [15:0]   hist_mem [HISTORY_DEPTH];
	logic [15:0]   wrom [HI + 1];

	logic [AW-1:0] addr_full;
	logic [PW-1:0] rd_addr;
	logic [16:0]   mul_a;
	logic [15:0]   mul_b;
	logic [33:0]   mix_sum;
	logic          out_free;
	logic          accept;

	for (genvar g = 0; g <= HI; g++) begin : g_wrom
		assign wrom[g] = bcs_pkg::weight_of(g, BEAT_PERIOD, WEIGHT_SHARPNESS);
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		if (AW'(ptr_q) >= AW'(k_q)) begin
			addr_full = AW'(ptr_q) - AW'(k_q);
		end else begin
			addr_full = AW'(ptr_q) + AW'(HISTORY_DEPTH) - AW'(k_q);
		end
		rd_addr = addr_full[PW-1:0];
	end

	always_comb begin
		case (state_q)
			ST_MULA: begin
				mul_a = 17'h10000 - {1'b0, blend_q};
				mul_b = sample_q;
			end
			ST_MULB: begin
				mul_a = {1'b0, blend_q};
				mul_b = best_q[31:16];
			end
			default: begin
				mul_a = {1'b0, rd_s1};
				mul_b = w_s1;
			end
		endcase
	end

	assign mix_sum = {1'b0, acc_q} + {1'b0, prod_s2} + 34'd32768;

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			hist_mem[ptr_q] <= score_q;
		end
		rd_s1 <= hist_mem[rd_addr];
		w_s1 <= wrom[k_q];
		prod_s2 <= 33'(mul_a) * 33'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			blend_q <= bcs_pkg::BLEND_RESET;
			ptr_q <= '0;
			fill_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				blend_q <= cfg_data;
			end
			v_s1 <= (state_q == ST_SCAN) && (FW'(k_q) <= fill_q);
			v_s2 <= v_s1;
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= SCAN_EMPTY ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (k_q == KW'(HI)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_MULA;
					end
				end
				ST_MULA: begin
					state_q <= ST_MULB;
				end
				ST_MULB: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						ptr_q <= (ptr_q == PW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
						if (fill_q != FW'(HISTORY_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_tdata;
			k_q <= KW'(LO);
			best_q <= '0;
		end else begin
			if (state_q == ST_SCAN && k_q != KW'(HI)) begin
				k_q <= k_q + 1'b1;
			end
			if (v_s2 && prod_s2[31:0] > best_q) begin
				best_q <= prod_s2[31:0];
			end
		end
		if (state_q == ST_MULB) begin
			acc_q <= prod_s2;
		end
		if (state_q == ST_SUM) begin
			score_q <= (mix_sum[33:32] != 2'b00) ? 16'hFFFF : mix_sum[31:16];
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= score_q;
		end
	end

	`BCS_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "input taken again while busy")
	`BCS_ASSERT_NOW(a_scan_only_in_scan, v_s2, (state_q == ST_SCAN) || (state_q == ST_DRAIN), "lag product outside the scan")
	`BCS_ASSERT_NEXT(a_ptr_moves, (state_q == ST_DONE) && out_free, (ptr_q != $past(ptr_q)) && m_tvalid, "history pointer or output not updated on completion")

endmodule
